>>> rtl/hdf_pkg.sv
// shared types, widths and codes of the hillslope diffusion flux block
package hdf_pkg;

  localparam int MaxNeighborsDef = 20;

  localparam int ElevW  = 32;
  localparam int LenW   = 32;
  localparam int DzW    = ElevW + 1;
  localparam int ProdW  = 2 * LenW;
  localparam int SumW   = 48;
  localparam int QuotW  = SumW + 1;
  localparam int ModeW  = 2;

  localparam int InTdataW  = 136;
  localparam int OutTdataW = 56;

  // largest term magnitude before the clamp, two to the power of the sum width
  localparam logic [QuotW-1:0] TermCap = {1'b1, {SumW{1'b0}}};

  localparam logic [ModeW-1:0] ModePlain    = 2'd0;
  localparam logic [ModeW-1:0] ModeDownhill = 2'd1;
  localparam logic [ModeW-1:0] ModeMarine   = 2'd2;

  typedef struct packed {
    logic             done;
    logic             over;
    logic [QuotW-1:0] quot;
  } div_res_t;

endpackage

>>> rtl/hdf_div.sv
// iterative restoring divider, one quotient bit per cycle through one shared subtractor
module hdf_div import hdf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [LenW-1:0]  divisor_i,
  output div_res_t         res_o
);

  localparam int DivSteps = QuotW + 1;
  localparam int CntW     = $clog2(DivSteps + 1);
  localparam int HiW      = ProdW - QuotW;

  logic             busy_q;
  logic             done_q;
  logic             over_q;
  logic [CntW-1:0]  cnt_q;
  logic [LenW-1:0]  rem_q;
  logic [QuotW-1:0] low_q;
  logic [QuotW-1:0] quot_q;

  logic            check;
  logic [LenW:0]   cand;
  logic [LenW:0]   diff;
  logic            ge;

  // first busy cycle tests whether the quotient reaches past the kept bits
  assign check = (cnt_q == CntW'(DivSteps));
  assign cand  = check ? {1'b0, rem_q} : {rem_q, low_q[QuotW-1]};
  assign ge    = (cand >= {1'b0, divisor_i});
  assign diff  = cand - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if ((check && ge) || (!check && cnt_q == CntW'(1))) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {{(LenW-HiW){1'b0}}, dividend_i[ProdW-1:QuotW]};
      low_q  <= dividend_i[QuotW-1:0];
      over_q <= 1'b0;
    end else if (busy_q) begin
      if (check) begin
        over_q <= ge;
      end else begin
        rem_q  <= ge ? diff[LenW-1:0] : cand[LenW-1:0];
        low_q  <= {low_q[QuotW-2:0], 1'b0};
        quot_q <= {quot_q[QuotW-2:0], ge};
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.over = over_q;
  assign res_o.quot = quot_q;

endmodule

>>> rtl/hdf_acc.sv
// saturating flux accumulator with term clamp and clip flag
module hdf_acc import hdf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            neg_i,
  input  div_res_t        res_i,
  output logic [SumW-1:0] sum_o,
  output logic            clip_o
);

  logic [SumW-1:0]        sum_q;
  logic                   clip_q;
  logic                   term_clip;
  logic [QuotW-1:0]       mag;
  logic signed [SumW+1:0] term;
  logic signed [SumW+1:0] total;
  logic                   sum_ovf;
  logic [SumW-1:0]        sum_sat;

  assign term_clip = res_i.over || (res_i.quot > TermCap);
  assign mag       = term_clip ? TermCap : res_i.quot;
  assign term      = neg_i ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign total     = $signed({{2{sum_q[SumW-1]}}, sum_q}) + term;

  // top three bits disagree when the sum left the signed range
  assign sum_ovf = !((total[SumW+1:SumW-1] == 3'b000) || (total[SumW+1:SumW-1] == 3'b111));
  assign sum_sat = total[SumW+1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      clip_q <= 1'b0;
    end else if (clear_i) begin
      sum_q  <= '0;
      clip_q <= 1'b0;
    end else if (res_i.done) begin
      sum_q  <= sum_ovf ? sum_sat : total[SumW-1:0];
      clip_q <= clip_q | term_clip | sum_ovf;
    end
  end

  assign sum_o  = sum_q;
  assign clip_o = clip_q;

endmodule

>>> rtl/hillslope_diffusion_flux_top.sv
// top level: neighbor stream in, node flux out, sequencer around the shared divider
// steps: an item that adds nothing is accepted in idle; a contributing item passes
//   accept, multiply, divider load, the divider range test (which ends an overflowing
//   divide early) and a step for each quotient bit, then the result write
// flow: one item at a time, as s_axis_tready is low outside idle; after a last item
//   the emit state moves the node result into the output register once it is free
// reset: asynchronous active low; sequencer to idle, counter, sum, flag, mode to zero
module hillslope_diffusion_flux_top import hdf_pkg::*; #(
  parameter int MaxNeighbors = MaxNeighborsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // center_elevation, center_inside, center_deposit, neighbor_elevation,
  // neighbor_inside, neighbor_deposit, edge_length, distance, zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // node_flux, flux_saturated, zero pad
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [ModeW-1:0]     cfg_data_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o
);

  localparam int CntW = $clog2(MaxNeighbors + 1);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StMul   = 5'b00010,
    StStart = 5'b00100,
    StDiv   = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [ModeW-1:0] mode_q;
  logic [CntW-1:0]  cnt_q;
  logic [LenW-1:0]  mag_q;
  logic             neg_q;
  logic [LenW-1:0]  edge_q;
  logic [LenW-1:0]  dist_q;
  logic             last_q;
  logic [ProdW-1:0] prod_q;
  logic             m_valid_q;
  logic [SumW-1:0]  flux_q;
  logic             sat_q;

  logic [ElevW-1:0] c_elev, n_elev;
  logic             c_in, c_dep, n_in, n_dep;
  logic [LenW-1:0]  in_edge, in_dist;
  logic [DzW-1:0]   dz;
  logic [DzW-1:0]   dz_abs;
  logic             dz_neg, dz_pos;
  logic             qual, room, contrib;
  logic             accept, emit_go;
  div_res_t         div_res;
  logic [SumW-1:0]  acc_sum;
  logic             acc_clip;

  assign c_elev  = s_axis_tdata[31:0];
  assign c_in    = s_axis_tdata[32];
  assign c_dep   = s_axis_tdata[33];
  assign n_elev  = s_axis_tdata[65:34];
  assign n_in    = s_axis_tdata[66];
  assign n_dep   = s_axis_tdata[67];
  assign in_edge = s_axis_tdata[99:68];
  assign in_dist = s_axis_tdata[131:100];

  assign dz     = {n_elev[ElevW-1], n_elev} - {c_elev[ElevW-1], c_elev};
  assign dz_neg = dz[DzW-1];
  assign dz_pos = !dz_neg && (dz != '0);
  assign dz_abs = dz_neg ? -dz : dz;

  always_comb begin
    qual = 1'b0;
    unique case (mode_q)
      ModePlain:    qual = n_in || dz_neg;
      ModeDownhill: qual = dz_neg;
      ModeMarine:   qual = n_in ? ((c_dep && dz_neg) || (n_dep && dz_pos)) : (dz_neg && c_dep);
      default:      qual = 1'b0;
    endcase
  end

  assign room    = (cnt_q < CntW'(MaxNeighbors));
  assign contrib = room && c_in && (in_dist != '0) && qual;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit_go       = (state_q == StEmit) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (contrib) begin
            state_d = StMul;
          end else if (s_axis_tlast) begin
            state_d = StEmit;
          end
        end
      end
      StMul:   state_d = StStart;
      StStart: state_d = StDiv;
      StDiv: begin
        if (div_res.done) begin
          state_d = last_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (emit_go) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      mode_q    <= ModePlain;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (emit_go) begin
        cnt_q <= '0;
      end else if (accept && room) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (emit_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag_q  <= dz_abs[LenW-1:0];
      neg_q  <= dz_neg;
      edge_q <= in_edge;
      dist_q <= in_dist;
      last_q <= s_axis_tlast;
    end
    if (state_q == StMul) begin
      prod_q <= ProdW'(mag_q) * ProdW'(edge_q);
    end
    if (emit_go) begin
      flux_q <= acc_sum;
      sat_q  <= acc_clip;
    end
  end

  hdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StStart),
    .dividend_i (prod_q),
    .divisor_i  (dist_q),
    .res_o      (div_res)
  );

  hdf_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (emit_go),
    .neg_i   (neg_q),
    .res_i   (div_res),
    .sum_o   (acc_sum),
    .clip_o  (acc_clip)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-SumW-1){1'b0}}, sat_q, flux_q};

  // divider result only arrives while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == StDiv))
    else $error("divider finished outside the divide state");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxNeighbors))
    else $error("neighbor count beyond its limit");

  a_contrib_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && contrib) |=> (state_q == StMul))
    else $error("contributing item did not start the multiply");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == StEmit))
    else $error("output item raised outside the emit state");

endmodule
